// ===== rtl/rssd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rssd_pkg;

    // Field widths of one transaction on either side.
    localparam int LOGM_W   = 4;
    localparam int TERMS_W  = 6;
    localparam int CNT_W    = 63;
    localparam int STATUS_W = 2;

    // Input tdata layout, lowest bit first.
    localparam int IN_L_LSB    = 0;
    localparam int IN_M_LSB    = IN_L_LSB + LOGM_W;
    localparam int IN_L1_LSB   = IN_M_LSB + TERMS_W;
    localparam int IN_MIN_LSB  = IN_L1_LSB + CNT_W;
    localparam int IN_MAX_LSB  = IN_MIN_LSB + CNT_W;
    localparam int IN_TDATA_W  = ((IN_MAX_LSB + CNT_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first.
    localparam int OUT_MEAN_LSB = 0;
    localparam int OUT_L1_LSB   = OUT_MEAN_LSB + CNT_W;
    localparam int OUT_MIN_LSB  = OUT_L1_LSB + CNT_W;
    localparam int OUT_MAX_LSB  = OUT_MIN_LSB + CNT_W;
    localparam int OUT_DEV_LSB  = OUT_MAX_LSB + CNT_W;
    localparam int OUT_ST_LSB   = OUT_DEV_LSB + CNT_W;
    localparam int OUT_USED_W   = OUT_ST_LSB + STATUS_W;
    localparam int OUT_TDATA_W  = ((OUT_USED_W + 7) / 8) * 8;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_PASS     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOTAL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISMATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_SHORT    = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/residue_subset_sum_distribution_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel   Direction  Ports            Contents
// s_axis    in         tvalid/tready    one run: L, m, expected L1, min and max
// m_axis    out        tvalid/tready    mean, L1, min, max, largest deviation, status
//
// A run of m terms with n = 2^L residues makes m counting passes and a statistics pass
// before its result transaction: each counting pass streams the count memory once,
// one entry per cycle through its two read ports, followed by a turnaround state, and
// the statistics pass streams it once more. A run with m below L skips every pass.
// Reset is synchronous and active low; the count memories need no clearing pass.
// A new run is taken while a result still waits; a stalled result holds the next one back.

module residue_subset_sum_distribution_core
    import rssd_pkg::*;
#(
    parameter int MAX_LOG_MODULUS = 12,
    parameter int MAX_TERMS       = 62
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // log_modulus, num_terms, expected_l1, expected_min, expected_max
    input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // uniform_mean, l1_distance, min_count, max_count, max_deviation, status
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW    = MAX_LOG_MODULUS;
    localparam int DEPTH = 1 << AW;
    localparam int LW    = $clog2(MAX_LOG_MODULUS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PASS  = 3'd1;
    localparam logic [2:0] S_GAP   = 3'd2;
    localparam logic [2:0] S_STATS = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]          r_state;
    logic                r_out_valid;

    logic [TERMS_W-1:0]  r_m;
    logic [AW-1:0]       r_mask;
    logic [AW-1:0]       r_weight;
    logic [AW-1:0]       r_addr;
    logic [TERMS_W-1:0]  r_pass;
    logic                r_first;
    logic                r_cur_b;
    logic                r_short;
    logic [CNT_W-1:0]    r_mean;
    logic [CNT_W-1:0]    r_exp_l1;
    logic [CNT_W-1:0]    r_exp_min;
    logic [CNT_W-1:0]    r_exp_max;

    logic [CNT_W-1:0]    r_mem_a [DEPTH];
    logic [CNT_W-1:0]    r_mem_b [DEPTH];
    logic [CNT_W-1:0]    r_qa0, r_qa1, r_qb0, r_qb1;

    logic                r_p1_pass;
    logic                r_p1_stat;
    logic [AW-1:0]       r_p1_addr;
    logic                r_p1_virt;
    logic                r_p1_curb;
    logic                r_p1_z0;
    logic                r_p1_z1;

    logic                r_s2_valid;
    logic [CNT_W-1:0]    r_s2_cnt;
    logic [CNT_W-1:0]    r_s2_dev;

    logic [63:0]         r_total;
    logic [63:0]         r_l1;
    logic [CNT_W-1:0]    r_min;
    logic [CNT_W-1:0]    r_max;
    logic [CNT_W-1:0]    r_maxdev;

    logic [CNT_W-1:0]    r_o_mean, r_o_l1, r_o_min, r_o_max, r_o_dev;
    logic [STATUS_W-1:0] r_o_status;

    logic [LOGM_W-1:0]   w_in_l;
    logic [TERMS_W-1:0]  w_in_m;
    logic [LW-1:0]       n_l;
    logic [TERMS_W-1:0]  n_m;
    logic                n_short;
    logic                w_in_acc;
    logic                w_out_free;
    logic                w_issue_pass;
    logic                w_issue_stat;
    logic [AW-1:0]       w_rd0;
    logic [AW-1:0]       w_rd1;
    logic [CNT_W-1:0]    w_c0;
    logic [CNT_W-1:0]    w_c1;
    logic [CNT_W-1:0]    w_sum;
    logic                w_we_a;
    logic                w_we_b;
    logic [STATUS_W-1:0] w_status;

    assign w_in_l = s_axis_tdata[IN_L_LSB +: LOGM_W];
    assign w_in_m = s_axis_tdata[IN_M_LSB +: TERMS_W];

    always_comb begin
        n_l = (32'(w_in_l) > MAX_LOG_MODULUS) ? LW'(MAX_LOG_MODULUS) : LW'(w_in_l);
        n_m = (32'(w_in_m) > MAX_TERMS) ? TERMS_W'(MAX_TERMS) : w_in_m;
        n_short = 32'(n_m) < 32'(n_l);
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_issue_pass  = (r_state == S_PASS);
    assign w_issue_stat  = (r_state == S_STATS);

    assign w_rd0 = r_addr;
    assign w_rd1 = (r_addr - r_weight) & r_mask;

    // Before the first pass the current table is the single count at residue zero,
    // so it is formed from the address instead of being written into memory.
    always_comb begin
        w_c0 = r_p1_virt ? CNT_W'(r_p1_z0) : (r_p1_curb ? r_qb0 : r_qa0);
        w_c1 = r_p1_virt ? CNT_W'(r_p1_z1) : (r_p1_curb ? r_qb1 : r_qa1);
        w_sum = w_c0 + w_c1;
    end

    assign w_we_a = r_p1_pass && r_p1_curb;
    assign w_we_b = r_p1_pass && !r_p1_curb;

    // The pass reads one table and writes the other; a turnaround state between
    // passes lets the last write land before the next pass reads it.
    always_ff @(posedge i_clk) begin
        if (w_we_a) begin
            r_mem_a[r_p1_addr] <= w_sum;
        end
        r_qa0 <= r_mem_a[w_rd0];
        r_qa1 <= r_mem_a[w_rd1];
    end

    always_ff @(posedge i_clk) begin
        if (w_we_b) begin
            r_mem_b[r_p1_addr] <= w_sum;
        end
        r_qb0 <= r_mem_b[w_rd0];
        r_qb1 <= r_mem_b[w_rd1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_pass  <= 1'b0;
            r_p1_stat  <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_p1_pass  <= w_issue_pass;
            r_p1_stat  <= w_issue_stat;
            r_s2_valid <= r_p1_stat;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p1_addr <= r_addr;
        r_p1_virt <= r_first;
        r_p1_curb <= r_cur_b;
        r_p1_z0   <= (w_rd0 == '0);
        r_p1_z1   <= (w_rd1 == '0);
        r_s2_cnt  <= w_c0;
        r_s2_dev  <= (w_c0 >= r_mean) ? (w_c0 - r_mean) : (r_mean - w_c0);
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_total  <= '0;
            r_l1     <= '0;
            r_min    <= '1;
            r_max    <= '0;
            r_maxdev <= '0;
        end else if (r_s2_valid) begin
            r_total <= r_total + 64'(r_s2_cnt);
            r_l1    <= r_l1 + 64'(r_s2_dev);
            if (r_s2_cnt < r_min) begin
                r_min <= r_s2_cnt;
            end
            if (r_s2_cnt > r_max) begin
                r_max <= r_s2_cnt;
            end
            if (r_s2_dev > r_maxdev) begin
                r_maxdev <= r_s2_dev;
            end
        end
    end

    // A wrong total outranks a mismatch against the expected figures.
    always_comb begin
        if (r_short) begin
            w_status = ST_SHORT;
        end else if (r_total != (64'd1 << r_m)) begin
            w_status = ST_TOTAL;
        end else if (r_l1 != {1'b0, r_exp_l1} || r_min != r_exp_min ||
                     r_max != r_exp_max) begin
            w_status = ST_MISMATCH;
        end else begin
            w_status = ST_PASS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (n_short) begin
                            r_state <= S_DONE;
                        end else if (n_m == '0) begin
                            r_state <= S_STATS;
                        end else begin
                            r_state <= S_PASS;
                        end
                    end
                end
                S_PASS: begin
                    if (r_addr == r_mask) begin
                        r_state <= S_GAP;
                    end
                end
                S_GAP: begin
                    if (r_pass + TERMS_W'(1) == r_m) begin
                        r_state <= S_STATS;
                    end else begin
                        r_state <= S_PASS;
                    end
                end
                S_STATS: begin
                    if (r_addr == r_mask) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (!r_p1_stat && !r_s2_valid) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_m       <= n_m;
                    r_mask    <= AW'((32'd1 << n_l) - 32'd1);
                    r_weight  <= AW'(1);
                    r_addr    <= '0;
                    r_pass    <= '0;
                    r_first   <= 1'b1;
                    r_cur_b   <= 1'b0;
                    r_short   <= n_short;
                    r_mean    <= CNT_W'(64'd1 << (n_m - TERMS_W'(n_l)));
                    r_exp_l1  <= s_axis_tdata[IN_L1_LSB +: CNT_W];
                    r_exp_min <= s_axis_tdata[IN_MIN_LSB +: CNT_W];
                    r_exp_max <= s_axis_tdata[IN_MAX_LSB +: CNT_W];
                end
            end
            S_PASS, S_STATS: begin
                r_addr <= r_addr + AW'(1);
            end
            S_GAP: begin
                r_addr   <= '0;
                r_weight <= (r_weight + (r_weight << 1)) & r_mask;
                r_pass   <= r_pass + TERMS_W'(1);
                r_first  <= 1'b0;
                r_cur_b  <= !r_cur_b;
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_o_status <= w_status;
                    if (r_short) begin
                        r_o_mean <= '0;
                        r_o_l1   <= '0;
                        r_o_min  <= '0;
                        r_o_max  <= '0;
                        r_o_dev  <= '0;
                    end else begin
                        r_o_mean <= r_mean;
                        r_o_l1   <= r_l1[CNT_W-1:0];
                        r_o_min  <= r_min;
                        r_o_max  <= r_max;
                        r_o_dev  <= r_maxdev;
                    end
                end
            end
            default: begin
                r_addr <= r_addr;
            end
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_USED_W)'(0), r_o_status, r_o_dev, r_o_max,
                            r_o_min, r_o_l1, r_o_mean};

endmodule

`default_nettype wire

// ===== rtl/rssd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rssd_checker
    import rssd_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   s_axis_tvalid,
    input wire                   s_axis_tready,
    input wire                   m_axis_tvalid,
    input wire                   m_axis_tready,
    input wire [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic [CNT_W-1:0]    w_mean, w_l1, w_min, w_max, w_dev;
    logic [STATUS_W-1:0] w_status;

    assign w_mean   = m_axis_tdata[OUT_MEAN_LSB +: CNT_W];
    assign w_l1     = m_axis_tdata[OUT_L1_LSB +: CNT_W];
    assign w_min    = m_axis_tdata[OUT_MIN_LSB +: CNT_W];
    assign w_max    = m_axis_tdata[OUT_MAX_LSB +: CNT_W];
    assign w_dev    = m_axis_tdata[OUT_DEV_LSB +: CNT_W];
    assign w_status = m_axis_tdata[OUT_ST_LSB +: STATUS_W];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Once a run is taken the block is not ready again in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second run taken straight after the first");

    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_status == ST_SHORT |->
            w_mean == '0 && w_l1 == '0 && w_min == '0 && w_max == '0 && w_dev == '0)
        else $error("short run result carries nonzero figures");

    // A counted run always has a nonzero mean, ordered extremes and a largest
    // deviation that cannot exceed the summed deviation.
    a_counted_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_status != ST_SHORT |->
            w_mean != '0 && w_max >= w_min && w_dev <= w_l1)
        else $error("inconsistent figures in counted result");

endmodule

bind residue_subset_sum_distribution_core rssd_checker u_rssd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ===== verif/residue_subset_sum_distribution_checker.sv =====
`timescale 1ns / 1ps

module residue_subset_sum_distribution_checker
    import rssd_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_run_valid,
    input  wire                   i_run_ready,
    // log_modulus, num_terms, expected_l1, expected_min, expected_max
    input  wire [IN_TDATA_W-1:0]  i_run_data,
    input  wire                   i_stat_valid,
    input  wire                   i_stat_ready,
    // uniform_mean, l1_distance, min_count, max_count, max_deviation, status
    input  wire [OUT_TDATA_W-1:0] i_stat_data,
    output int                    o_pending,
    output int                    o_failures
);

    localparam int LOG_LIMIT   = 12;
    localparam int TERMS_LIMIT = 62;
    localparam int DEPTH       = 1 << LOG_LIMIT;

    typedef struct packed {
        logic [CNT_W-1:0]    mean;
        logic [CNT_W-1:0]    l1;
        logic [CNT_W-1:0]    min_c;
        logic [CNT_W-1:0]    max_c;
        logic [CNT_W-1:0]    max_dev;
        logic [STATUS_W-1:0] status;
    } run_stats_t;

    run_stats_t stats_q[$];
    int         pending_cnt = 0;
    int         fail_count  = 0;

    assign o_pending  = pending_cnt;
    assign o_failures = fail_count;

    // Returns zero when the clamped term count is below the clamped exponent, in which
    // case no counting takes place. The statistics are kept at 64 bits, as the L1 sum
    // can reach the top bit for the largest term counts.
    function automatic bit count_residues(
        input  logic [LOGM_W-1:0]  log_mod,
        input  logic [TERMS_W-1:0] terms,
        output logic [63:0]        mean,
        output logic [63:0]        l1,
        output logic [63:0]        min_c,
        output logic [63:0]        max_c,
        output logic [63:0]        max_dev,
        output bit                 total_ok
    );
        logic [63:0] cur [DEPTH];
        logic [63:0] nxt [DEPTH];
        logic [63:0] dev;
        logic [63:0] total;
        int unsigned n_l, n_m, width, mask, weight, r, i;
        n_l = (log_mod > LOG_LIMIT) ? LOG_LIMIT : log_mod;
        n_m = (terms > TERMS_LIMIT) ? TERMS_LIMIT : terms;
        mean     = '0;
        l1       = '0;
        min_c    = '0;
        max_c    = '0;
        max_dev  = '0;
        total_ok = 1'b0;
        if (n_m < n_l) begin
            return 1'b0;
        end
        width = 1 << n_l;
        mask  = width - 1;
        for (r = 0; r < width; r++) begin
            cur[r] = '0;
        end
        cur[0] = 64'd1;
        weight = 1;
        for (i = 0; i < n_m; i++) begin
            for (r = 0; r < width; r++) begin
                nxt[r] = cur[r] + cur[(r - weight) & mask];
            end
            for (r = 0; r < width; r++) begin
                cur[r] = nxt[r];
            end
            weight = (3 * weight) & mask;
        end
        mean  = 64'd1 << (n_m - n_l);
        min_c = '1;
        total = '0;
        for (r = 0; r < width; r++) begin
            dev = (cur[r] >= mean) ? cur[r] - mean : mean - cur[r];
            total += cur[r];
            l1    += dev;
            if (cur[r] < min_c) min_c = cur[r];
            if (cur[r] > max_c) max_c = cur[r];
            if (dev > max_dev) max_dev = dev;
        end
        total_ok = (total == (64'd1 << n_m));
        return 1'b1;
    endfunction

    function automatic run_stats_t predict_run(input logic [IN_TDATA_W-1:0] data);
        run_stats_t  res;
        logic [63:0] mean, l1, min_c, max_c, max_dev;
        logic [63:0] want_l1, want_min, want_max;
        bit          total_ok;
        res      = '0;
        want_l1  = {1'b0, data[IN_L1_LSB +: CNT_W]};
        want_min = {1'b0, data[IN_MIN_LSB +: CNT_W]};
        want_max = {1'b0, data[IN_MAX_LSB +: CNT_W]};
        if (!count_residues(data[IN_L_LSB +: LOGM_W], data[IN_M_LSB +: TERMS_W],
                            mean, l1, min_c, max_c, max_dev, total_ok)) begin
            res.status = ST_SHORT;
        end else begin
            res.mean    = mean[CNT_W-1:0];
            res.l1      = l1[CNT_W-1:0];
            res.min_c   = min_c[CNT_W-1:0];
            res.max_c   = max_c[CNT_W-1:0];
            res.max_dev = max_dev[CNT_W-1:0];
            if (!total_ok) begin
                res.status = ST_TOTAL;
            end else if (l1 != want_l1 || min_c != want_min || max_c != want_max) begin
                res.status = ST_MISMATCH;
            end else begin
                res.status = ST_PASS;
            end
        end
        return res;
    endfunction

    task automatic check_field(input string name, input logic [CNT_W-1:0] want,
                               input logic [CNT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin : watch
        run_stats_t want;
        if (i_rst_n) begin
            if (i_run_valid && i_run_ready) begin
                stats_q.insert(stats_q.size(), predict_run(i_run_data));
            end
            if (i_stat_valid && i_stat_ready) begin
                if (stats_q.size() == 0) begin
                    $error("result transaction arrived with no run waiting for it");
                    fail_count++;
                end else begin
                    want = stats_q.pop_front();
                    check_field("uniform_mean", want.mean,
                                i_stat_data[OUT_MEAN_LSB +: CNT_W]);
                    check_field("l1_distance", want.l1,
                                i_stat_data[OUT_L1_LSB +: CNT_W]);
                    check_field("min_count", want.min_c,
                                i_stat_data[OUT_MIN_LSB +: CNT_W]);
                    check_field("max_count", want.max_c,
                                i_stat_data[OUT_MAX_LSB +: CNT_W]);
                    check_field("max_deviation", want.max_dev,
                                i_stat_data[OUT_DEV_LSB +: CNT_W]);
                    check_field("status", CNT_W'(want.status),
                                CNT_W'(i_stat_data[OUT_ST_LSB +: STATUS_W]));
                end
            end
            pending_cnt <= stats_q.size();
        end
    end

endmodule

// ===== verif/residue_subset_sum_distribution_core_test.sv =====
`timescale 1ns / 1ps

module residue_subset_sum_distribution_core_test;
    import rssd_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int RANDOM_RUNS = 80;
    localparam int DRAIN_WAIT  = 20;

    typedef enum {
        EXP_EXACT,
        EXP_NUDGED,
        EXP_RANDOM,
        EXP_ZERO,
        EXP_ONES
    } exp_pick_t;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    bit calm        = 1'b0;
    int cycles      = 0;
    int runs_sent   = 0;
    int short_runs  = 0;
    int pending;
    int failures;

    residue_subset_sum_distribution_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    residue_subset_sum_distribution_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_run_valid  (s_axis_tvalid),
        .i_run_ready  (s_axis_tready),
        .i_run_data   (s_axis_tdata),
        .i_stat_valid (m_axis_tvalid),
        .i_stat_ready (m_axis_tready),
        .i_stat_data  (m_axis_tdata),
        .o_pending    (pending),
        .o_failures   (failures)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 13);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[residue_subset_sum_distribution_core] ERROR");
            $finish;
        end
    end

    function automatic logic [CNT_W-1:0] rand_count();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[CNT_W-1:0];
    endfunction

    // Presents one run and holds it until the core takes the transaction.
    task automatic send_run(input logic [LOGM_W-1:0] log_mod, input logic [TERMS_W-1:0] terms,
                            input logic [CNT_W-1:0] e_l1, input logic [CNT_W-1:0] e_min,
                            input logic [CNT_W-1:0] e_max);
        logic [IN_TDATA_W-1:0] data;
        data = '0;
        data[IN_L_LSB +: LOGM_W]  = log_mod;
        data[IN_M_LSB +: TERMS_W] = terms;
        data[IN_L1_LSB +: CNT_W]  = e_l1;
        data[IN_MIN_LSB +: CNT_W] = e_min;
        data[IN_MAX_LSB +: CNT_W] = e_max;
        while (!calm && $urandom_range(0, 99) < 13) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
        runs_sent++;
    endtask

    // The exact statistics are worked out first so that passing runs can be built;
    // the other picks disturb or replace them.
    task automatic send_checked(input logic [LOGM_W-1:0] log_mod,
                                input logic [TERMS_W-1:0] terms, input exp_pick_t pick);
        logic [63:0]      mean, l1, min_c, max_c, max_dev;
        logic [CNT_W-1:0] e_l1, e_min, e_max;
        bit               total_ok;
        if (!u_checker.count_residues(log_mod, terms, mean, l1, min_c, max_c, max_dev,
                                      total_ok)) begin
            short_runs++;
        end
        e_l1  = l1[CNT_W-1:0];
        e_min = min_c[CNT_W-1:0];
        e_max = max_c[CNT_W-1:0];
        case (pick)
            EXP_NUDGED: begin
                case ($urandom_range(0, 2))
                    0:       e_l1[$urandom_range(0, CNT_W-1)]  ^= 1'b1;
                    1:       e_min[$urandom_range(0, CNT_W-1)] ^= 1'b1;
                    default: e_max[$urandom_range(0, CNT_W-1)] ^= 1'b1;
                endcase
            end
            EXP_RANDOM: begin
                e_l1  = rand_count();
                e_min = rand_count();
                e_max = rand_count();
            end
            EXP_ZERO: begin
                e_l1  = '0;
                e_min = '0;
                e_max = '0;
            end
            EXP_ONES: begin
                e_l1  = '1;
                e_min = '1;
                e_max = '1;
            end
            default: ;
        endcase
        send_run(log_mod, terms, e_l1, e_min, e_max);
    endtask

    initial begin : stimulus
        logic [LOGM_W-1:0]  log_mod;
        logic [TERMS_W-1:0] terms;
        exp_pick_t          pick;
        int                 k;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed runs: a single residue, runs with too few terms, exponents and
        // term counts beyond their clamps, and every kind of expected-value outcome.
        send_checked(4'd0, 6'd0, EXP_EXACT);
        send_checked(4'd0, 6'd62, EXP_RANDOM);
        send_checked(4'd1, 6'd0, EXP_EXACT);
        send_checked(4'd12, 6'd11, EXP_ONES);
        send_checked(4'd15, 6'd0, EXP_ZERO);
        send_checked(4'd15, 6'd12, EXP_EXACT);
        send_checked(4'd12, 6'd63, EXP_EXACT);
        send_checked(4'd1, 6'd1, EXP_EXACT);
        send_checked(4'd2, 6'd2, EXP_NUDGED);
        send_checked(4'd4, 6'd10, EXP_NUDGED);
        send_checked(4'd5, 6'd9, EXP_NUDGED);
        send_checked(4'd6, 6'd6, EXP_ZERO);
        send_checked(4'd7, 6'd20, EXP_RANDOM);
        send_checked(4'd8, 6'd8, EXP_EXACT);
        send_checked(4'd3, 6'd62, EXP_ONES);
        send_checked(4'd2, 6'd63, EXP_EXACT);
        send_checked(4'd9, 6'd10, EXP_EXACT);
        send_checked(4'd3, 6'd5, EXP_EXACT);
        send_checked(4'd10, 6'd10, EXP_NUDGED);
        send_checked(4'd6, 6'd63, EXP_RANDOM);

        // Let the core drain completely before the random part starts.
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        // Mostly small moduli so that runs stay short; now and then a wide one with
        // just enough terms to be counted.
        for (k = 0; k < RANDOM_RUNS; k++) begin
            calm <= (k >= 40 && k < 70);
            if (k % 25 == 12) begin
                log_mod = LOGM_W'($urandom_range(8, 15));
                terms   = TERMS_W'(((log_mod > 12) ? 12 : log_mod) + $urandom_range(0, 2));
            end else begin
                log_mod = LOGM_W'($urandom_range(0, 6));
                terms   = TERMS_W'($urandom_range(0, 63));
            end
            case ($urandom_range(0, 3))
                0, 1:    pick = EXP_EXACT;
                2:       pick = EXP_NUDGED;
                default: pick = EXP_RANDOM;
            endcase
            send_checked(log_mod, terms, pick);
        end
        calm <= 1'b0;
        s_axis_tvalid <= 1'b0;

        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Ran %0d transactions of counting work, %0d of them with fewer terms than",
                 runs_sent, short_runs);
        $display("the exponent, over moduli up to 2^12 with stalls on both channels.");
        if (failures == 0 && pending == 0) begin
            $display("[residue_subset_sum_distribution_core] OK");
        end else begin
            $display("[residue_subset_sum_distribution_core] ERROR");
        end
        $finish;
    end

endmodule
